### sv/wgd_pkg.sv
`default_nettype none

package wgd_pkg;

   localparam int MAX_CORES   = 1024;
   localparam int MAX_WARPS   = 32;
   localparam int MAX_THREADS = 32;

   localparam int TASK_W     = 31;
   localparam int GRID_W     = 16;
   localparam int CORE_CNT_W = 11;
   localparam int CNT_W      = 6;
   localparam int CORE_W     = 10;
   localparam int WARP_W     = 5;
   localparam int THR_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int XY_W       = 2 * GRID_W;
   localparam int TOT_W      = 3 * GRID_W;
   localparam int IDX_W      = 3;
   localparam int DIV_CNT_W  = $clog2(TASK_W);

   localparam logic [TOT_W-1:0] TASK_LIMIT = TOT_W'(32'h7FFF_FFFF);

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BIG  = 2'd2;

   localparam logic [IDX_W-1:0] REG_GRID_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_GRID_Y  = 3'd1;
   localparam logic [IDX_W-1:0] REG_GRID_Z  = 3'd2;
   localparam logic [IDX_W-1:0] REG_CORES   = 3'd3;
   localparam logic [IDX_W-1:0] REG_WARPS   = 3'd4;
   localparam logic [IDX_W-1:0] REG_THREADS = 3'd5;

   // per-core split of a share into warp batches
   typedef struct packed {
      logic [TASK_W-1:0] share;
      logic [TASK_W-1:0] tw;
      logic [CNT_W-1:0]  rt;
      logic [TASK_W-1:0] fw;
      logic [CNT_W-1:0]  rw;
   } share_type;

   typedef struct packed {
      logic                  too_large;
      logic                  empty;
      logic [CORE_CNT_W-1:0] ncores;
      logic [TASK_W-1:0]     per_core;
      logic [CNT_W-1:0]      nw;
      logic [CNT_W-1:0]      nt;
      logic [XY_W-1:0]       xy;
      logic [GRID_W-1:0]     grid_x;
      share_type             share_mid;
      share_type             share_last;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   task_id;
      logic                last_slot;
   } work_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                last_slot;
      logic [TASK_W-1:0]   task_id;
      logic [XY_W-1:0]     rem;
      logic [GRID_W-1:0]   qk;
      logic [GRID_W-1:0]   qj;
   } pipe_type;

endpackage

`default_nettype wire

### sv/wgd_divider.sv
`default_nettype none

module wgd_divider (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [wgd_pkg::TASK_W-1:0]      dividend,
   input  wire  [wgd_pkg::CORE_CNT_W-1:0]  divisor,
   output logic                            done,
   output logic [wgd_pkg::TASK_W-1:0]      quotient,
   output logic [wgd_pkg::CORE_CNT_W-1:0]  remainder
);
   import wgd_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic [TASK_W-1:0]     quot_ff;
   logic [CORE_CNT_W-1:0] rem_ff;
   logic [CORE_CNT_W-1:0] divisor_ff;
   logic [CORE_CNT_W:0]   trial;
   logic [CORE_CNT_W:0]   diff;
   logic                  fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quot_ff[TASK_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            count_ff <= DIV_CNT_W'(TASK_W - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[TASK_W-2:0], fits};
         rem_ff <= fits ? diff[CORE_CNT_W-1:0] : trial[CORE_CNT_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### sv/wgd_setup.sv
`default_nettype none

module wgd_setup (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [wgd_pkg::IDX_W-1:0]    csr_index,
   input  wire  [wgd_pkg::GRID_W-1:0]   csr_data,
   output logic                         busy,
   output wgd_pkg::cfg_type             cfg
);
   import wgd_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MUL_XY  = 4'd1;
   localparam logic [3:0] ST_MUL_TOT = 4'd2;
   localparam logic [3:0] ST_CHECK   = 4'd3;
   localparam logic [3:0] ST_DIV_NC  = 4'd4;
   localparam logic [3:0] ST_DIV_PC  = 4'd5;
   localparam logic [3:0] ST_DIV_TWM = 4'd6;
   localparam logic [3:0] ST_DIV_FWM = 4'd7;
   localparam logic [3:0] ST_DIV_TWL = 4'd8;
   localparam logic [3:0] ST_DIV_FWL = 4'd9;

   logic [GRID_W-1:0]     grid_x_ff, grid_y_ff, grid_z_ff;
   logic [CORE_CNT_W-1:0] core_count_ff;
   logic [CNT_W-1:0]      warps_ff, threads_ff;
   logic [3:0]            state_ff, state_in;
   logic                  launched_ff, launched_in;
   logic [XY_W-1:0]       xy_ff;
   logic [TOT_W-1:0]      total_ff;
   logic [CORE_CNT_W-1:0] wt_ff;
   cfg_type               cfg_ff;

   logic [CORE_CNT_W-1:0] nc_max;
   logic [CNT_W-1:0]      nw, nt;
   logic                  wr;
   logic                  div_start, div_done;
   logic [TASK_W-1:0]     div_dividend, div_q;
   logic [CORE_CNT_W-1:0] div_divisor, div_r;

   assign wr = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   assign nc_max = (core_count_ff > CORE_CNT_W'(MAX_CORES)) ? CORE_CNT_W'(MAX_CORES)
                                                            : core_count_ff;
   assign nw = (warps_ff > CNT_W'(MAX_WARPS)) ? CNT_W'(MAX_WARPS) : warps_ff;
   assign nt = (threads_ff > CNT_W'(MAX_THREADS)) ? CNT_W'(MAX_THREADS) : threads_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_W'(1);
         grid_y_ff <= GRID_W'(1);
         grid_z_ff <= GRID_W'(1);
         core_count_ff <= CORE_CNT_W'(1);
         warps_ff <= CNT_W'(4);
         threads_ff <= CNT_W'(4);
         state_ff <= ST_MUL_XY;
         launched_ff <= 1'b0;
      end else if (wr) begin
         case (csr_index)
            REG_GRID_X:  grid_x_ff <= csr_data;
            REG_GRID_Y:  grid_y_ff <= csr_data;
            REG_GRID_Z:  grid_z_ff <= csr_data;
            REG_CORES:   core_count_ff <= csr_data[CORE_CNT_W-1:0];
            REG_WARPS:   warps_ff <= csr_data[CNT_W-1:0];
            REG_THREADS: threads_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
         state_ff <= ST_MUL_XY;
         launched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launched_ff <= launched_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      launched_in = launched_ff;
      div_start = 1'b0;
      div_dividend = total_ff[TASK_W-1:0];
      div_divisor = wt_ff;
      case (state_ff)
         ST_IDLE: ;
         ST_MUL_XY: state_in = ST_MUL_TOT;
         ST_MUL_TOT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (total_ff > TASK_LIMIT || total_ff == '0 || nc_max == '0 ||
                nw == '0 || nt == '0) begin
               state_in = ST_IDLE;
            end else if (total_ff > TOT_W'(wt_ff)) begin
               state_in = ST_DIV_NC;
            end else begin
               state_in = ST_DIV_PC;
            end
         end
         default: begin
            case (state_ff)
               ST_DIV_NC: begin
                  div_dividend = total_ff[TASK_W-1:0];
                  div_divisor = wt_ff;
               end
               ST_DIV_PC: begin
                  div_dividend = total_ff[TASK_W-1:0];
                  div_divisor = cfg_ff.ncores;
               end
               ST_DIV_TWM: begin
                  div_dividend = cfg_ff.share_mid.share;
                  div_divisor = CORE_CNT_W'(nt);
               end
               ST_DIV_FWM: begin
                  div_dividend = cfg_ff.share_mid.tw;
                  div_divisor = CORE_CNT_W'(nw);
               end
               ST_DIV_TWL: begin
                  div_dividend = cfg_ff.share_last.share;
                  div_divisor = CORE_CNT_W'(nt);
               end
               default: begin
                  div_dividend = cfg_ff.share_last.tw;
                  div_divisor = CORE_CNT_W'(nw);
               end
            endcase
            if (!launched_ff) begin
               div_start = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               case (state_ff)
                  ST_DIV_NC:  state_in = ST_DIV_PC;
                  ST_DIV_PC:  state_in = ST_DIV_TWM;
                  ST_DIV_TWM: state_in = ST_DIV_FWM;
                  ST_DIV_FWM: state_in = ST_DIV_TWL;
                  ST_DIV_TWL: state_in = ST_DIV_FWL;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_MUL_XY: begin
            xy_ff <= XY_W'(grid_x_ff) * XY_W'(grid_y_ff);
            wt_ff <= CORE_CNT_W'(CORE_CNT_W'(nw) * CORE_CNT_W'(nt));
         end
         ST_MUL_TOT: total_ff <= TOT_W'(xy_ff) * TOT_W'(grid_z_ff);
         ST_CHECK: begin
            cfg_ff.too_large <= total_ff > TASK_LIMIT;
            cfg_ff.empty <= total_ff == '0 || nc_max == '0 || nw == '0 || nt == '0;
            cfg_ff.ncores <= CORE_CNT_W'(1);
            cfg_ff.nw <= nw;
            cfg_ff.nt <= nt;
            cfg_ff.xy <= xy_ff;
            cfg_ff.grid_x <= grid_x_ff;
         end
         default: begin
            if (launched_ff && div_done) begin
               case (state_ff)
                  ST_DIV_NC: begin
                     cfg_ff.ncores <= (div_q > TASK_W'(nc_max)) ? nc_max
                                                               : div_q[CORE_CNT_W-1:0];
                  end
                  ST_DIV_PC: begin
                     cfg_ff.per_core <= div_q;
                     cfg_ff.share_mid.share <= div_q;
                     cfg_ff.share_last.share <= div_q + TASK_W'(div_r);
                  end
                  ST_DIV_TWM: begin
                     cfg_ff.share_mid.tw <= div_q;
                     cfg_ff.share_mid.rt <= div_r[CNT_W-1:0];
                  end
                  ST_DIV_FWM: begin
                     if (cfg_ff.share_mid.tw >= TASK_W'(nw)) begin
                        cfg_ff.share_mid.fw <= div_q;
                        cfg_ff.share_mid.rw <= div_r[CNT_W-1:0];
                     end else begin
                        cfg_ff.share_mid.fw <= TASK_W'(1);
                        cfg_ff.share_mid.rw <= '0;
                     end
                  end
                  ST_DIV_TWL: begin
                     cfg_ff.share_last.tw <= div_q;
                     cfg_ff.share_last.rt <= div_r[CNT_W-1:0];
                  end
                  default: begin
                     if (cfg_ff.share_last.tw >= TASK_W'(nw)) begin
                        cfg_ff.share_last.fw <= div_q;
                        cfg_ff.share_last.rw <= div_r[CNT_W-1:0];
                     end else begin
                        cfg_ff.share_last.fw <= TASK_W'(1);
                        cfg_ff.share_last.rw <= '0;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   wgd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign busy = state_ff != ST_IDLE;
   assign cfg  = cfg_ff;

endmodule

`default_nettype wire

### sv/wgd_front.sv
`default_nettype none

module wgd_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          busy,
   input  wgd_pkg::cfg_type             cfg,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [wgd_pkg::CORE_W-1:0]   req_core_index,
   input  wire  [wgd_pkg::WARP_W-1:0]   req_warp_index,
   input  wire  [wgd_pkg::THR_W-1:0]    req_thread_index,
   input  wire  [wgd_pkg::TASK_W-1:0]   req_slot,
   input  wire                          push_ok,
   output logic                         push,
   output wgd_pkg::work_type            push_data
);
   import wgd_pkg::*;

   logic adv, take;

   // stage 1: classify, pick the share, first products
   logic                  s1_valid_ff;
   logic [STATUS_W-1:0]   s1_status_ff;
   logic [THR_W-1:0]      s1_thr_ff;
   logic [TASK_W-1:0]     s1_slot_ff;
   logic [TASK_W:0]       s1_main_ff;
   logic                  s1_rem_ff;
   logic [TASK_W-1:0]     s1_base_ff;
   logic [TASK_W-1:0]     s1_wk_ff;
   logic [CNT_W-1:0]      s1_nt_ff;
   logic [TASK_W-1:0]     s1_share_ff;
   logic [CNT_W-1:0]      s1_rt_ff;

   // stage 2: offsets inside the core
   logic                  s2_valid_ff;
   logic [STATUS_W-1:0]   s2_status_ff;
   logic [TASK_W-1:0]     s2_base_ff;
   logic [TASK_W-1:0]     s2_wkn_ff;
   logic [TASK_W-1:0]     s2_thrm_ff;
   logic [TASK_W-1:0]     s2_slot_ff;
   logic [TASK_W-1:0]     s2_off_ff;
   logic                  s2_lt_ff;
   logic                  s2_eq_ff;
   logic                  s2_last_ff;

   logic                  out_valid_ff;
   work_type              out_ff;

   share_type             sh;
   logic                  is_last, exists;
   logic [CNT_W-1:0]      warp_x, thr_x, warp_cap, rw_min;
   logic [STATUS_W-1:0]   status1;
   logic [TASK_W:0]       main1;
   logic [TASK_W:0]       slot_x;

   assign adv  = !out_valid_ff || push_ok;
   assign take = req_valid && !req_stall;
   assign req_stall = busy || !adv;

   assign warp_x  = CNT_W'(req_warp_index);
   assign thr_x   = CNT_W'(req_thread_index);
   assign is_last = CORE_CNT_W'(req_core_index) == cfg.ncores - 1'b1;
   assign sh      = is_last ? cfg.share_last : cfg.share_mid;
   assign exists  = warp_x < cfg.nw && thr_x < cfg.nt &&
                    CORE_CNT_W'(req_core_index) < cfg.ncores;

   always_comb begin
      if (cfg.too_large) begin
         status1 = STATUS_BIG;
      end else if (cfg.empty || !exists) begin
         status1 = STATUS_NONE;
      end else begin
         status1 = STATUS_OK;
      end
   end

   // warps that run a main batch: min(tw, nw)
   assign warp_cap = (sh.tw >= TASK_W'(cfg.nw)) ? cfg.nw : sh.tw[CNT_W-1:0];
   assign main1 = (warp_x < warp_cap) ? ({1'b0, sh.fw} + (TASK_W+1)'(warp_x < sh.rw))
                                      : '0;
   assign rw_min = (sh.rw < warp_x) ? sh.rw : warp_x;

   assign slot_x = {1'b0, s1_slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_status_ff <= status1;
         s1_thr_ff <= req_thread_index;
         s1_slot_ff <= req_slot;
         s1_main_ff <= main1;
         s1_rem_ff <= sh.rt != '0 && req_warp_index == '0 && thr_x < sh.rt;
         s1_base_ff <= TASK_W'(req_core_index) * cfg.per_core;
         s1_wk_ff <= sh.fw * TASK_W'(req_warp_index) + TASK_W'(rw_min);
         s1_nt_ff <= cfg.nt;
         s1_share_ff <= sh.share;
         s1_rt_ff <= sh.rt;

         s2_status_ff <= s1_status_ff;
         s2_base_ff <= s1_base_ff;
         s2_wkn_ff <= s1_wk_ff * TASK_W'(s1_nt_ff);
         s2_thrm_ff <= TASK_W'(s1_main_ff[TASK_W-1:0] * TASK_W'(s1_thr_ff));
         s2_slot_ff <= s1_slot_ff;
         s2_off_ff <= s1_share_ff - TASK_W'(s1_rt_ff) + TASK_W'(s1_thr_ff);
         s2_lt_ff <= slot_x < s1_main_ff;
         s2_eq_ff <= slot_x == s1_main_ff && s1_rem_ff;
         s2_last_ff <= (slot_x + 1'b1) == s1_main_ff + (TASK_W+1)'(s1_rem_ff);

         if (s2_status_ff != STATUS_OK) begin
            out_ff.status <= s2_status_ff;
            out_ff.task_id <= '0;
            out_ff.last_slot <= 1'b0;
         end else if (s2_lt_ff) begin
            out_ff.status <= STATUS_OK;
            out_ff.task_id <= s2_base_ff + s2_wkn_ff + s2_thrm_ff + s2_slot_ff;
            out_ff.last_slot <= s2_last_ff;
         end else if (s2_eq_ff) begin
            out_ff.status <= STATUS_OK;
            out_ff.task_id <= s2_base_ff + s2_off_ff;
            out_ff.last_slot <= s2_last_ff;
         end else begin
            out_ff.status <= STATUS_NONE;
            out_ff.task_id <= '0;
            out_ff.last_slot <= 1'b0;
         end
      end
   end

   assign push      = out_valid_ff && push_ok;
   assign push_data = out_ff;

endmodule

`default_nettype wire

### sv/wgd_back.sv
`default_nettype none

module wgd_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wgd_pkg::work_type            push_data,
   output logic                         push_ok,
   input  wire  [wgd_pkg::XY_W-1:0]     xy,
   input  wire  [wgd_pkg::GRID_W-1:0]   grid_x,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [wgd_pkg::STATUS_W-1:0] rsp_status,
   output logic [wgd_pkg::TASK_W-1:0]   rsp_task_id,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_i,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_j,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_k,
   output logic                         rsp_last_slot
);
   import wgd_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int NSTEP  = 2 * GRID_W;

   work_type              q_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]       count_ff;
   logic                  pop, adv;

   pipe_type              pipe_ff  [NSTEP+1];
   logic [NSTEP:0]        valid_ff;

   assign push_ok = count_ff != (QPTR_W+1)'(QDEPTH);
   assign adv     = !valid_ff[NSTEP] || !rsp_stall;
   assign pop     = adv && count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NSTEP-1:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0].status <= q_ff[rd_ptr_ff].status;
         pipe_ff[0].last_slot <= q_ff[rd_ptr_ff].last_slot;
         pipe_ff[0].task_id <= q_ff[rd_ptr_ff].task_id;
         pipe_ff[0].rem <= XY_W'(q_ff[rd_ptr_ff].task_id);
         pipe_ff[0].qk <= '0;
         pipe_ff[0].qj <= '0;
      end
   end

   // k = id / (X*Y) over the first GRID_W steps, then j = rest / X
   // failed queries keep zero coordinates (an empty grid may have X*Y = 0)
   for (genvar s = 1; s <= NSTEP; s++) begin : g_step
      localparam int BIT = (s <= GRID_W) ? GRID_W - s : NSTEP - s;
      pipe_type             cur;
      logic [TOT_W-1:0]     dvs;
      logic                 ge;

      always_comb begin
         cur = pipe_ff[s-1];
         if (s <= GRID_W) begin
            dvs = TOT_W'(xy) << BIT;
         end else begin
            dvs = TOT_W'(grid_x) << BIT;
         end
         ge = cur.status == STATUS_OK && TOT_W'(cur.rem) >= dvs;
         if (ge) begin
            cur.rem = cur.rem - dvs[XY_W-1:0];
            if (s <= GRID_W) begin
               cur.qk[BIT] = 1'b1;
            end else begin
               cur.qj[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) pipe_ff[s] <= cur;
      end
   end

   assign rsp_valid     = valid_ff[NSTEP];
   assign rsp_status    = pipe_ff[NSTEP].status;
   assign rsp_task_id   = pipe_ff[NSTEP].task_id;
   assign rsp_group_i   = pipe_ff[NSTEP].rem[GRID_W-1:0];
   assign rsp_group_j   = pipe_ff[NSTEP].qj;
   assign rsp_group_k   = pipe_ff[NSTEP].qk;
   assign rsp_last_slot = pipe_ff[NSTEP].last_slot;

endmodule

`default_nettype wire

### sv/workgroup_grid_dispatcher.sv
// Workgroup grid dispatcher: for each (core, warp, thread, slot) query it returns the
// workgroup of the X*Y*Z grid that slot runs, as a flat task id, its (i,j,k)
// coordinates, a last-slot mark and a status (ok, no task, grid too large). Queries
// stream at one transfer per cycle while no setup pass runs and the result side
// never stalls: a 3-stage front classifies the query and builds the task id, a
// 4-entry queue decouples it from the back end, and the back end is a 33-stage
// long-division pipeline (16 steps for k, 16 for j) that yields the coordinates.
// Everything that depends on the configuration alone (grid product, active cores,
// per-core share, warp batch split) is computed once by a serial divider after reset
// and after every register write; this setup pass runs the multiplies and then up to
// six divisions, and req_stall stays high while it runs. Registers may be written at
// any time the block is idle.

`default_nettype none

module workgroup_grid_dispatcher (
   input  wire                          clock,
   input  wire                          reset,
   // config write channel
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [wgd_pkg::IDX_W-1:0]    csr_index,
   input  wire  [wgd_pkg::GRID_W-1:0]   csr_data,
   // query channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [wgd_pkg::CORE_W-1:0]   req_core_index,
   input  wire  [wgd_pkg::WARP_W-1:0]   req_warp_index,
   input  wire  [wgd_pkg::THR_W-1:0]    req_thread_index,
   input  wire  [wgd_pkg::TASK_W-1:0]   req_slot,
   // result channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [wgd_pkg::STATUS_W-1:0] rsp_status,
   output logic [wgd_pkg::TASK_W-1:0]   rsp_task_id,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_i,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_j,
   output logic [wgd_pkg::GRID_W-1:0]   rsp_group_k,
   output logic                         rsp_last_slot
);
   import wgd_pkg::*;

   cfg_type  cfg;
   logic     busy;
   logic     push, push_ok;
   work_type push_data;

   // setup: registers plus precompute of the per-core split
   wgd_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .cfg       (cfg)
   );

   // front: classify the query and form the flat task id
   wgd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .busy             (busy),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_core_index   (req_core_index),
      .req_warp_index   (req_warp_index),
      .req_thread_index (req_thread_index),
      .req_slot         (req_slot),
      .push_ok          (push_ok),
      .push             (push),
      .push_data        (push_data)
   );

   // back: queue, then split the id into (i,j,k)
   wgd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .push_data     (push_data),
      .push_ok       (push_ok),
      .xy            (cfg.xy),
      .grid_x        (cfg.grid_x),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_task_id   (rsp_task_id),
      .rsp_group_i   (rsp_group_i),
      .rsp_group_j   (rsp_group_j),
      .rsp_group_k   (rsp_group_k),
      .rsp_last_slot (rsp_last_slot)
   );

`ifndef ASSERT_OFF
   // failed queries carry all-zero fields through the coordinate pipeline
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_task_id == '0 && rsp_group_i == '0 && rsp_group_j == '0 &&
         rsp_group_k == '0 && !rsp_last_slot)
      else $error("failed query with nonzero fields");

   // no query may enter while the setup pass is running
   a_stall_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("query accepted during setup");

   // i is the remainder of a division by X
   a_i_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_group_i < cfg.grid_x)
      else $error("group_i out of range");
`endif

endmodule

`default_nettype wire
